>>> hw/rtl/mqsa_pkg.sv
// Package: constants, codes and types shared by the aging scheduler.
package mqsa_pkg;

    localparam int unsigned TableSlotsDef = 16;

    // Register reset values
    localparam logic [15:0] IntervalRst = 16'd1500;
    localparam logic [7:0]  StepRst     = 8'd10;
    localparam logic [7:0]  TopRst      = 8'd100;
    localparam logic [7:0]  MidRst      = 8'd50;
    localparam logic [7:0]  CeilRst     = 8'd149;

    // Register indexes
    localparam logic [2:0] RegInterval = 3'd0;
    localparam logic [2:0] RegStep     = 3'd1;
    localparam logic [2:0] RegTop      = 3'd2;
    localparam logic [2:0] RegMid      = 3'd3;
    localparam logic [2:0] RegCeil     = 3'd4;

    // Result status codes
    localparam logic [1:0] StEnq     = 2'd0;
    localparam logic [1:0] StDisp    = 2'd1;
    localparam logic [1:0] StNone    = 2'd2;
    localparam logic [1:0] StFull    = 2'd3;

    // Level codes
    localparam logic [1:0] LvBurst = 2'd1;
    localparam logic [1:0] LvPrio  = 2'd2;
    localparam logic [1:0] LvFifo  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ_RD,
        S_ENQ_WR,
        S_DEQ_RD,
        S_DEQ_SCAN,
        S_DEQ_DONE
    } t_state;

    // One table entry
    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  prio;
        logic [31:0] burst;
        logic [31:0] ready;
        logic [31:0] arrival;
    } t_entry;

endpackage

>>> hw/rtl/multilevel_queue_scheduler_aging_unit.sv
// Top level: APB register file, task table memory and enqueue/dequeue sequencer.
//
//  channel  | direction | ports                                      | beat marker
//  ---------+-----------+--------------------------------------------+---------------
//  request  | in        | i_kind i_task_id i_task_priority           | i_start & !o_busy
//           |           | i_burst_estimate i_now                     |
//  result   | out       | o_status o_chosen_id o_chosen_level        | o_done (1 cycle)
//           |           | o_chosen_priority                          |
//  config   | in/out    | psel penable pwrite paddr pwdata prdata    | psel&penable&pwrite
//
// Enqueue picks the lowest free slot, then writes the entry. Dequeue does one memory read
// per slot with aging written back the next cycle, then the winner is cleared.
// Slot valid bits live in flip-flops cleared by reset; payload memory needs none.
// The result strobe lasts one cycle and o_busy stays low from that cycle on.
module multilevel_queue_scheduler_aging_unit
    import mqsa_pkg::*;
#(
    parameter int unsigned TABLE_SLOTS = TableSlotsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic        i_kind,
    input  logic [15:0] i_task_id,
    input  logic [7:0]  i_task_priority,
    input  logic [31:0] i_burst_estimate,
    input  logic [31:0] i_now,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [15:0] o_chosen_id,
    output logic [1:0]  o_chosen_level,
    output logic [7:0]  o_chosen_priority,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int unsigned CW = $clog2(TABLE_SLOTS + 1);

    // ---------------- configuration registers
    logic [15:0] r_interval;
    logic [7:0]  r_step, r_top, r_mid, r_ceil;
    logic [2:0]  w_ridx;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_ridx = paddr[4:2];
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= IntervalRst;
            r_step     <= StepRst;
            r_top      <= TopRst;
            r_mid      <= MidRst;
            r_ceil     <= CeilRst;
        end else if (w_wr) begin
            case (w_ridx)
                RegInterval: r_interval <= pwdata[15:0];
                RegStep:     r_step     <= pwdata[7:0];
                RegTop:      r_top      <= pwdata[7:0];
                RegMid:      r_mid      <= pwdata[7:0];
                RegCeil:     r_ceil     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_ridx)
            RegInterval: prdata = {16'd0, r_interval};
            RegStep:     prdata = {24'd0, r_step};
            RegTop:      prdata = {24'd0, r_top};
            RegMid:      prdata = {24'd0, r_mid};
            RegCeil:     prdata = {24'd0, r_ceil};
            default:     prdata = 32'd0;
        endcase
    end

    // ---------------- state and request latch
    t_state        r_state, n_state;
    logic [TABLE_SLOTS-1:0] r_valid;
    logic [31:0]   r_arr_cnt;
    logic [15:0]   r_in_id;
    logic [7:0]    r_in_prio;
    logic [31:0]   r_in_burst, r_now;
    logic [CW-1:0] r_idx;       // slot being read
    logic [IW-1:0] r_wb_idx;    // slot whose data is on the read port
    logic          r_have_best;
    logic [IW-1:0] r_best_idx;
    t_entry        r_best;
    logic [IW-1:0] r_free_idx;
    logic          r_free_ok;

    // Memory: one write port, one registered read port
    t_entry        r_mem [TABLE_SLOTS];
    t_entry        r_rd;
    logic          w_mem_we;
    logic [IW-1:0] w_mem_wa;
    t_entry        w_mem_wd;
    logic [IW-1:0] w_mem_ra;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) r_mem[w_mem_wa] <= w_mem_wd;
        r_rd <= r_mem[w_mem_ra];
    end

    assign w_mem_ra = r_idx[IW-1:0];

    // ---------------- level and ordering helpers
    function automatic logic [1:0] level_of(input logic [7:0] p, input logic [7:0] top,
                                            input logic [7:0] mid);
        if (p >= top)      level_of = LvBurst;
        else if (p >= mid) level_of = LvPrio;
        else               level_of = LvFifo;
    endfunction

    // Aging of the entry just read
    t_entry     w_aged;
    logic [8:0] w_psum;
    logic       w_age;
    assign w_age  = (r_now - r_rd.ready) >= {16'd0, r_interval};
    assign w_psum = {1'b0, r_rd.prio} + {1'b0, r_step};
    always_comb begin
        w_aged = r_rd;
        if (w_age) begin
            w_aged.prio  = (w_psum > {1'b0, r_ceil}) ? r_ceil : w_psum[7:0];
            w_aged.ready = r_now;
        end
    end

    // Compare aged entry against best so far
    logic [1:0] w_la, w_lb;
    logic       w_better;
    assign w_la = level_of(w_aged.prio, r_top, r_mid);
    assign w_lb = level_of(r_best.prio, r_top, r_mid);
    always_comb begin
        if (w_la != w_lb)
            w_better = w_la < w_lb;
        else if (w_la == LvBurst && w_aged.burst != r_best.burst)
            w_better = w_aged.burst < r_best.burst;
        else if (w_la == LvPrio && w_aged.prio != r_best.prio)
            w_better = w_aged.prio > r_best.prio;
        else if (w_la != LvFifo && w_aged.id != r_best.id)
            w_better = w_aged.id < r_best.id;
        else
            w_better = (r_arr_cnt - w_aged.arrival) > (r_arr_cnt - r_best.arrival);
    end

    // Lowest free slot, found over the valid bits
    logic [IW-1:0] w_free_idx;
    logic          w_free_ok;
    always_comb begin
        w_free_idx = '0;
        w_free_ok  = 1'b0;
        for (int s = TABLE_SLOTS - 1; s >= 0; s--) begin
            if (!r_valid[s]) begin
                w_free_idx = IW'(s);
                w_free_ok  = 1'b1;
            end
        end
    end

    logic w_accept, w_scan_v, w_last;
    assign w_accept = i_start & ~o_busy;
    assign w_scan_v = r_valid[r_wb_idx];
    assign w_last   = (r_idx == CW'(TABLE_SLOTS));

    // ---------------- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:     if (w_accept) n_state = i_kind ? S_DEQ_RD : S_ENQ_RD;
            S_ENQ_RD:   n_state = S_ENQ_WR;
            S_ENQ_WR:   n_state = S_IDLE;
            S_DEQ_RD:   n_state = S_DEQ_SCAN;
            S_DEQ_SCAN: if (w_last) n_state = S_DEQ_DONE;
            S_DEQ_DONE: n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // ---------------- memory write control
    always_comb begin
        w_mem_we = 1'b0;
        w_mem_wa = r_wb_idx;
        w_mem_wd = w_aged;
        case (r_state)
            S_ENQ_WR: begin
                w_mem_we = r_free_ok;
                w_mem_wa = r_free_idx;
                w_mem_wd = '{id: r_in_id, prio: r_in_prio, burst: r_in_burst,
                             ready: r_now, arrival: r_arr_cnt};
            end
            S_DEQ_SCAN: w_mem_we = w_scan_v;
            default: ;
        endcase
    end

    // ---------------- sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_arr_cnt   <= '0;
            r_idx       <= '0;
            r_have_best <= 1'b0;
            o_done      <= 1'b0;
        end else begin
            r_state <= n_state;
            o_done  <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_idx       <= '0;
                    r_have_best <= 1'b0;
                end
                S_ENQ_RD: ;
                S_ENQ_WR: begin
                    o_done <= 1'b1;
                    if (r_free_ok) begin
                        r_valid[r_free_idx] <= 1'b1;
                        r_arr_cnt <= r_arr_cnt + 32'd1;
                    end
                end
                S_DEQ_RD: r_idx <= r_idx + CW'(1);
                S_DEQ_SCAN: begin
                    if (!w_last) r_idx <= r_idx + CW'(1);
                    if (w_scan_v && (!r_have_best || w_better)) r_have_best <= 1'b1;
                end
                S_DEQ_DONE: begin
                    o_done <= 1'b1;
                    if (r_have_best) r_valid[r_best_idx] <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_wb_idx <= r_idx[IW-1:0];
        if (w_accept) begin
            r_in_id    <= i_task_id;
            r_in_prio  <= i_task_priority;
            r_in_burst <= i_burst_estimate;
            r_now      <= i_now;
        end
        if (r_state == S_ENQ_RD) begin
            r_free_idx <= w_free_idx;
            r_free_ok  <= w_free_ok;
        end
        if (r_state == S_DEQ_SCAN && w_scan_v && (!r_have_best || w_better)) begin
            r_best     <= w_aged;
            r_best_idx <= r_wb_idx;
        end
    end

    // ---------------- result fields
    always_ff @(posedge i_clk) begin
        if (r_state == S_ENQ_WR) begin
            o_status          <= r_free_ok ? StEnq : StFull;
            o_chosen_id       <= '0;
            o_chosen_level    <= '0;
            o_chosen_priority <= '0;
        end else if (r_state == S_DEQ_DONE) begin
            o_status          <= r_have_best ? StDisp : StNone;
            o_chosen_id       <= r_have_best ? r_best.id : 16'd0;
            o_chosen_level    <= r_have_best ? level_of(r_best.prio, r_top, r_mid) : 2'd0;
            o_chosen_priority <= r_have_best ? r_best.prio : 8'd0;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

>>> dv/sched_checker.sv
// Scheduler checker: watches request, config and result channels, predicts and compares.
`timescale 1ns / 1ps
module sched_checker
    import mqsa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_kind,
    input  logic [15:0] i_task_id,
    input  logic [7:0]  i_task_priority,
    input  logic [31:0] i_burst_estimate,
    input  logic [31:0] i_now,
    input  logic        i_done,
    input  logic [1:0]  i_status,
    input  logic [15:0] i_chosen_id,
    input  logic [1:0]  i_chosen_level,
    input  logic [7:0]  i_chosen_priority,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_errors,
    output int          o_pending
);

    localparam int Slots = TableSlotsDef;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] id;
        logic [1:0]  level;
        logic [7:0]  prio;
    } t_dispatch;

    t_dispatch   dispatch_q[$];
    int          fail_count = 0;
    int          queued = 0;

    // Shadow of the task table and registers
    bit          live[Slots];
    t_entry      slot[Slots];
    logic [31:0] arrival_count;
    logic [15:0] interval;
    logic [7:0]  step, top_thr, mid_thr, ceiling;

    assign o_errors  = fail_count;
    assign o_pending = queued;

    task automatic report(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic logic [1:0] level_of(input logic [7:0] p);
        if (p >= top_thr) return LvBurst;
        if (p >= mid_thr) return LvPrio;
        return LvFifo;
    endfunction

    // True when slot a is served ahead of slot b
    function automatic bit served_first(input int a, input int b);
        logic [1:0] la, lb;
        la = level_of(slot[a].prio);
        lb = level_of(slot[b].prio);
        if (la != lb) return la < lb;
        if (la == LvBurst && slot[a].burst != slot[b].burst)
            return slot[a].burst < slot[b].burst;
        if (la == LvPrio && slot[a].prio != slot[b].prio)
            return slot[a].prio > slot[b].prio;
        if (la != LvFifo && slot[a].id != slot[b].id)
            return slot[a].id < slot[b].id;
        return (arrival_count - slot[a].arrival) > (arrival_count - slot[b].arrival);
    endfunction

    function automatic t_dispatch schedule(input logic kind, input logic [15:0] id,
                                           input logic [7:0] prio, input logic [31:0] burst,
                                           input logic [31:0] now);
        t_dispatch   r;
        int          best;
        logic [8:0]  raised;
        r = '0;
        best = -1;
        if (kind == 1'b0) begin
            for (int s = 0; s < Slots; s++)
                if (!live[s] && best < 0) best = s;
            if (best < 0) begin
                r.status = StFull;
                return r;
            end
            live[best] = 1'b1;
            slot[best] = '{id: id, prio: prio, burst: burst, ready: now,
                           arrival: arrival_count};
            arrival_count++;
            r.status = StEnq;
            return r;
        end
        // aging pass
        for (int s = 0; s < Slots; s++) begin
            if (live[s] && (now - slot[s].ready) >= {16'd0, interval}) begin
                raised = slot[s].prio + step;
                slot[s].prio  = (raised > ceiling) ? ceiling : raised[7:0];
                slot[s].ready = now;
            end
        end
        for (int s = 0; s < Slots; s++)
            if (live[s] && (best < 0 || served_first(s, best))) best = s;
        if (best < 0) begin
            r.status = StNone;
            return r;
        end
        live[best] = 1'b0;
        r.status = StDisp;
        r.id     = slot[best].id;
        r.level  = level_of(slot[best].prio);
        r.prio   = slot[best].prio;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_dispatch want;
        if (!i_rst_n) begin
            for (int s = 0; s < Slots; s++) live[s] = 1'b0;
            arrival_count = '0;
            interval = IntervalRst;
            step     = StepRst;
            top_thr  = TopRst;
            mid_thr  = MidRst;
            ceiling  = CeilRst;
            dispatch_q.delete();
        end else begin
            // result beat against the oldest prediction
            if (i_done) begin
                if (dispatch_q.size() == 0) begin
                    report("result beat with nothing expected");
                end else begin
                    want = dispatch_q.pop_front();
                    if (i_status !== want.status)
                        report($sformatf("status %0d, expected %0d", i_status, want.status));
                    if (i_chosen_id !== want.id)
                        report($sformatf("chosen_id %0d, expected %0d", i_chosen_id, want.id));
                    if (i_chosen_level !== want.level)
                        report($sformatf("chosen_level %0d, expected %0d",
                                         i_chosen_level, want.level));
                    if (i_chosen_priority !== want.prio)
                        report($sformatf("chosen_priority %0d, expected %0d",
                                         i_chosen_priority, want.prio));
                end
            end
            // register write
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    RegInterval: interval = i_pwdata[15:0];
                    RegStep:     step     = i_pwdata[7:0];
                    RegTop:      top_thr  = i_pwdata[7:0];
                    RegMid:      mid_thr  = i_pwdata[7:0];
                    RegCeil:     ceiling  = i_pwdata[7:0];
                    default: ;
                endcase
            end
            // request beat
            if (i_start && !i_busy)
                dispatch_q.push_back(schedule(i_kind, i_task_id, i_task_priority,
                                              i_burst_estimate, i_now));
        end
        queued = dispatch_q.size();
    end

endmodule

>>> dv/testbench.sv
// Testbench top: clock, reset, register setup and request stimulus for the aging scheduler.
`timescale 1ns / 1ps
module testbench;
    import mqsa_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        i_kind = 1'b0;
    logic [15:0] i_task_id = '0;
    logic [7:0]  i_task_priority = '0;
    logic [31:0] i_burst_estimate = '0;
    logic [31:0] i_now = '0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        o_busy, o_done, pready;
    logic [1:0]  o_status, o_chosen_level;
    logic [15:0] o_chosen_id;
    logic [7:0]  o_chosen_priority;
    logic [31:0] prdata;
    int          errors, pending;

    logic [31:0] tick = 32'd0;
    int          cur_interval = IntervalRst;
    bit          allow_idle = 1'b1;

    multilevel_queue_scheduler_aging_unit dut (.*);

    sched_checker u_checker (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_kind, .i_task_id,
        .i_task_priority, .i_burst_estimate, .i_now, .i_done(o_done),
        .i_status(o_status), .i_chosen_id(o_chosen_id), .i_chosen_level(o_chosen_level),
        .i_chosen_priority(o_chosen_priority), .i_psel(psel), .i_penable(penable),
        .i_pwrite(pwrite), .i_pready(pready), .i_paddr(paddr), .i_pwdata(pwdata),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    // One request beat; called and returns at a falling edge
    task automatic send(input logic kind, input logic [15:0] id, input logic [7:0] prio,
                        input logic [31:0] burst, input logic [31:0] now);
        if (allow_idle && $urandom_range(0, 5) == 0) begin
            i_start = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_start = 1'b1;
        i_kind = kind;
        i_task_id = id;
        i_task_priority = prio;
        i_burst_estimate = burst;
        i_now = now;
        while (o_busy) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        while (!pready) @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Drain outstanding work, then let the block settle
    task automatic settle();
        i_start = 1'b0;
        @(negedge i_clk);
        while (pending != 0 || o_busy) @(negedge i_clk);
        repeat (TableSlotsDef + 8) @(negedge i_clk);
    endtask

    task automatic configure(input logic [15:0] ivl, input logic [7:0] stp,
                             input logic [7:0] top, input logic [7:0] mid,
                             input logic [7:0] ceil);
        settle();
        reg_write(RegInterval, {16'd0, ivl});
        reg_write(RegStep, {24'd0, stp});
        reg_write(RegTop, {24'd0, top});
        reg_write(RegMid, {24'd0, mid});
        reg_write(RegCeil, {24'd0, ceil});
        cur_interval = ivl;
    endtask

    // Random requests in chunks with a varying enqueue bias
    task automatic random_phase(input int count);
        int enq_pct;
        logic [15:0] id;
        logic [31:0] burst;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) enq_pct = 30 + 20 * $urandom_range(0, 2);
            case ($urandom_range(0, 19))
                0:       tick = $urandom;
                1:       tick = tick + $urandom_range(0, 2 * cur_interval);
                default: tick = tick + $urandom_range(0, cur_interval / 3 + 1);
            endcase
            id = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
            burst = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 15) : $urandom;
            send($urandom_range(0, 99) < enq_pct ? 1'b0 : 1'b1, id,
                 8'($urandom_range(0, 149)), burst, tick);
        end
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: empty table, mixed levels with ties, table full, dequeues with aging
        send(1'b1, 16'd0, 8'd0, 32'd0, 32'd0);
        send(1'b0, 16'd5, 8'd149, 32'd7, 32'd0);
        send(1'b0, 16'd3, 8'd100, 32'd7, 32'd1);
        send(1'b0, 16'd3, 8'd120, 32'd7, 32'd2);
        send(1'b0, 16'd9, 8'd100, 32'hFFFF_FFFF, 32'd3);
        send(1'b0, 16'hFFFF, 8'd99, 32'd0, 32'd4);
        send(1'b0, 16'd1, 8'd99, 32'd1, 32'd5);
        send(1'b0, 16'd1, 8'd50, 32'd2, 32'd6);
        send(1'b0, 16'd1, 8'd50, 32'd2, 32'd7);
        send(1'b0, 16'd2, 8'd49, 32'd3, 32'hFFFF_FFF0);
        send(1'b0, 16'd0, 8'd0, 32'd4, 32'd8);
        send(1'b0, 16'd7, 8'd45, 32'd5, 32'd9);
        send(1'b0, 16'd8, 8'd1, 32'd6, 32'd10);
        send(1'b0, 16'd4, 8'd145, 32'd0, 32'd11);
        send(1'b0, 16'd6, 8'd128, 32'd0, 32'd12);
        send(1'b0, 16'd10, 8'd30, 32'd8, 32'd13);
        send(1'b0, 16'd11, 8'd90, 32'd9, 32'd14);
        send(1'b0, 16'd12, 8'd60, 32'd9, 32'd15);
        send(1'b1, 16'd0, 8'd0, 32'd0, 32'd20);
        send(1'b1, 16'd0, 8'd0, 32'd0, 32'd1600);
        send(1'b1, 16'd0, 8'd0, 32'd0, 32'd1700);
        send(1'b1, 16'd0, 8'd0, 32'd0, 32'd3200);
        send(1'b1, 16'd0, 8'd0, 32'd0, 32'd3300);
        send(1'b1, 16'd0, 8'd0, 32'd0, 32'd5000);
        tick = 32'd5000;
        random_phase(240);

        configure(16'd1, 8'd0, 8'd149, 8'd0, 8'd0);
        random_phase(250);
        configure(16'hFFFF, 8'd149, 8'd0, 8'd149, 8'd255);
        random_phase(250);
        configure(16'd300, 8'd25, 8'd50, 8'd100, 8'd120);
        random_phase(250);
        configure(16'($urandom_range(1, 65535)), 8'($urandom_range(0, 149)),
                  8'($urandom_range(0, 149)), 8'($urandom_range(0, 149)),
                  8'($urandom));
        random_phase(250);
        configure(IntervalRst, StepRst, TopRst, MidRst, CeilRst);
        allow_idle = 1'b0;
        random_phase(280);

        settle();
        if (errors == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
